FILE: rtl/online_bridge_counter_top_defines.svh
// Assertion macros shared by the online bridge counter RTL.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef ONLINE_BRIDGE_COUNTER_TOP_DEFINES_SVH
`define ONLINE_BRIDGE_COUNTER_TOP_DEFINES_SVH

// Property that holds at every clock edge out of reset.
`define OBC_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Same-cycle implication.
`define OBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/obc_pkg.sv
// Types and constants for the online bridge counter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package obc_pkg;

  localparam int VW = 10;           // vertex number width
  localparam int VX = VW + 1;       // vertex with a "none" code
  localparam int CW = 11;           // vertex_count width
  localparam int SW = 32;           // visit stamp width
  localparam logic [VX-1:0] NONE = '1;

  typedef logic [VX-1:0] vtx_t;

  typedef struct packed {
    logic [VW-1:0] vertex_a;
    logic [VW-1:0] vertex_b;
  } in_word_t;

  typedef struct packed {
    logic [VW-1:0] bridge_count;
    logic          index_error;
  } out_word_t;

  // one entry of per-vertex state
  typedef struct packed {
    logic [VW-1:0] bl;   // block leader
    logic [VW-1:0] cl;   // component leader
    logic [VX-1:0] tp;   // tree parent
    logic [VX-1:0] ts;   // tree size
    logic [SW-1:0] vs;   // visit stamp
  } state_word_t;

  typedef struct packed {
    logic          re;
    logic [VW-1:0] raddr;
    logic          we;
    logic [VW-1:0] waddr;
    state_word_t   wdata;
  } state_req_t;

  // path store address: side bit, then index
  typedef struct packed {
    logic          re;
    logic [VW:0]   raddr;
    logic          we;
    logic [VW:0]   waddr;
    logic [VW-1:0] wdata;
  } path_req_t;

  typedef enum logic [5:0] {
    S_INIT, S_IDLE,
    S_BR_RD, S_BR_CK, S_BC_CK, S_BC_WR,
    S_A1, S_B1,
    S_CR_RD, S_CR_CK, S_CR_RET, S_CX_CK, S_CX_BO, S_CX_RD, S_CX_WR,
    S_CMP, S_CMP_A, S_CMP_B,
    S_RR_CK, S_RR_BO, S_RR_RD, S_RR_WR, S_RR_END, S_RR_SZ,
    S_LK_WR, S_SZ_RD, S_SZ_WR,
    S_WIPE_RD, S_WIPE_WR,
    S_MG, S_MA_RD, S_MA_CK, S_MB, S_MB_RD, S_MB_CK,
    S_MM_PR, S_MM_RD, S_MM_WR,
    S_DONE
  } st_e;

endpackage
`default_nettype wire

FILE: rtl/online_bridge_counter_top.sv
// Top level of the online bridge counter: sequencer plus two memories.
// Uses obc_pkg, obc_seq, obc_state_mem, obc_path_mem.
`timescale 1ns / 1ps
`default_nettype none
// Online bridge counter. Each word on in_word_i is one undirected edge; a word is
// taken when start is high and busy is low, and exactly one result word follows on
// result_o with a one-cycle done_o strobe. The receiver cannot stall, so done_o
// must be sampled every cycle. After reset the block sweeps its state memory,
// one entry a cycle, and holds busy until every entry (at most 1024) is set.
// An out-of-range edge answers in the cycle right after it is taken, with
// index_error set, and busy never rises for it.
// A valid edge is quickest when its ends are already in one block; otherwise the
// time grows with the walked path lengths, since each forest step reads an entry
// and then checks it or writes it back. When the 32-bit visit stamp wraps, an
// extra pass reads and rewrites every entry to clear all stamps. vertex_count is
// written through cfg_we_i/cfg_wdata_i; the user must write it only while idle,
// and the block itself does not enforce this.
module online_bridge_counter_top
  import obc_pkg::*;
#(
  parameter int MAX_VERTICES = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire in_word_t      in_word_i,
  input  wire logic          cfg_we_i,
  input  wire logic [CW-1:0] cfg_wdata_i,
  output logic               done_o,
  output out_word_t          result_o
);

  // vertex numbers are 10 bits, so at most 1024 entries are ever touched
  localparam int DEPTH = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;
  localparam int AW    = $clog2(DEPTH);

  state_req_t    smem_req;
  state_word_t   smem_rdata;
  path_req_t     pmem_req;
  logic [VW-1:0] pmem_rdata;

  obc_seq #(
    .MAX_VERTICES (MAX_VERTICES),
    .DEPTH        (DEPTH),
    .AW           (AW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .in_word_i    (in_word_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .result_o     (result_o),
    .smem_req_o   (smem_req),
    .smem_rdata_i (smem_rdata),
    .pmem_req_o   (pmem_req),
    .pmem_rdata_i (pmem_rdata)
  );

  // leaders, tree parent, size and stamp per vertex
  obc_state_mem #(.DEPTH(DEPTH), .AW(AW)) u_state_mem (
    .clk_i   (clk_i),
    .req_i   (smem_req),
    .rdata_o (smem_rdata)
  );

  // both climbed paths of a cycle merge
  obc_path_mem #(.DEPTH(DEPTH), .AW(AW)) u_path_mem (
    .clk_i   (clk_i),
    .req_i   (pmem_req),
    .rdata_o (pmem_rdata)
  );

endmodule
`default_nettype wire

FILE: rtl/obc_state_mem.sv
// Per-vertex state memory: one write port, one read port, registered read.
// Uses obc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module obc_state_mem
  import obc_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic        clk_i,
  input  wire state_req_t  req_i,
  output state_word_t      rdata_o
);

  state_word_t mem [DEPTH];
  state_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/obc_path_mem.sv
// Scratch store for the two block paths of a cycle merge, registered read.
// Uses obc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module obc_path_mem
  import obc_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic       clk_i,
  input  wire path_req_t  req_i,
  output logic [VW-1:0]   rdata_o
);

  // one bank per side, so any depth maps without holes
  logic [VW-1:0] mem [2][DEPTH];
  logic [VW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[VW]][req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr[VW]][req_i.raddr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/obc_seq.sv
// Sequencer: walks the union-find and block forests in the state memory.
// Uses obc_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "online_bridge_counter_top_defines.svh"
module obc_seq
  import obc_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int DEPTH        = 1024,
  parameter int AW           = 10
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire in_word_t      in_word_i,
  input  wire logic          cfg_we_i,
  input  wire logic [CW-1:0] cfg_wdata_i,
  output logic               done_o,
  output out_word_t          result_o,
  output state_req_t         smem_req_o,
  input  wire state_word_t   smem_rdata_i,
  output path_req_t          pmem_req_o,
  input  wire logic [VW-1:0] pmem_rdata_i
);

  st_e state_q, state_d;
  st_e bo_ret_q, bo_ret_d;

  logic [AW-1:0]  sw_q, sw_d;
  logic [SW-1:0]  stamp_q, stamp_d;
  logic [VW-1:0]  bridge_q, bridge_d;
  logic [CW-1:0]  vcount_q, vcount_d;
  logic           done_q, done_d;
  out_word_t      res_q, res_d;

  vtx_t bo_v_q, bo_v_d, bo_root_q, bo_root_d, bo_x_q, bo_x_d;
  vtx_t va_q, va_d, vb_q, vb_d, ca_q, ca_d, cb_q, cb_d;
  vtx_t cr_q, cr_d, cx_q, cx_d;
  vtx_t top_q, top_d, cur_q, cur_d, below_q, below_d, lca_q, lca_d;
  logic           csel_q, csel_d, mside_q, mside_d;
  logic [VX-1:0]  sz_q, sz_d;
  logic [AW:0]    na_q, na_d, nb_q, nb_d, mi_q, mi_d;
  logic [VW-1:0]  pidx_q, pidx_d;

  state_word_t rd;
  logic        err_w, sw_last, swap_w;
  logic [AW:0] mcnt;
  vtx_t        rd_cl, rd_bl;

  assign rd      = smem_rdata_i;
  assign rd_cl   = {1'b0, rd.cl};
  assign rd_bl   = {1'b0, rd.bl};
  assign sw_last = (sw_q == AW'(DEPTH - 1));
  assign mcnt    = mside_q ? nb_q : na_q;
  assign swap_w  = (sz_q > rd.ts);
  assign err_w   = ({1'b0, in_word_i.vertex_a} >= vcount_q) ||
                   ({1'b0, in_word_i.vertex_b} >= vcount_q) ||
                   (32'(in_word_i.vertex_a) >= MAX_VERTICES) ||
                   (32'(in_word_i.vertex_b) >= MAX_VERTICES);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT:    if (sw_last) state_d = S_IDLE;
      S_IDLE:    if (start_i && !err_w) state_d = S_BR_RD;
      S_BR_RD:   state_d = S_BR_CK;
      S_BR_CK:   state_d = (rd_bl == bo_root_q) ? S_BC_CK : S_BR_RD;
      S_BC_CK:   state_d = (bo_x_q == bo_root_q) ? bo_ret_q : S_BC_WR;
      S_BC_WR:   state_d = S_BC_CK;
      S_A1:      state_d = S_BR_RD;
      S_B1:      state_d = (va_q == bo_root_q) ? S_DONE : S_CR_RD;
      S_CR_RD:   state_d = S_CR_CK;
      S_CR_CK:   state_d = (rd_cl == cr_q) ? S_CX_CK : S_BR_RD;
      S_CR_RET:  state_d = S_CR_RD;
      S_CX_CK: begin
        if (cx_q == cr_q) state_d = csel_q ? S_CMP : S_CR_RD;
        else              state_d = S_CX_BO;
      end
      S_CX_BO:   state_d = S_BR_RD;
      S_CX_RD:   state_d = S_CX_WR;
      S_CX_WR:   state_d = S_CX_CK;
      S_CMP: begin
        if (ca_q != cb_q)      state_d = S_CMP_A;
        else if (&stamp_q)     state_d = S_WIPE_RD;
        else                   state_d = S_MG;
      end
      S_CMP_A:   state_d = S_CMP_B;
      S_CMP_B:   state_d = S_RR_CK;
      S_RR_CK:   state_d = (cur_q == NONE) ? S_RR_END : S_RR_BO;
      S_RR_BO:   state_d = (rd.tp == NONE) ? S_RR_RD : S_BR_RD;
      S_RR_RD:   state_d = S_RR_WR;
      S_RR_WR:   state_d = S_RR_CK;
      S_RR_END:  state_d = S_RR_SZ;
      S_RR_SZ:   state_d = S_LK_WR;
      S_LK_WR:   state_d = S_SZ_RD;
      S_SZ_RD:   state_d = S_SZ_WR;
      S_SZ_WR:   state_d = S_DONE;
      S_WIPE_RD: state_d = S_WIPE_WR;
      S_WIPE_WR: state_d = sw_last ? S_MG : S_WIPE_RD;
      S_MG: begin
        if (va_q == NONE && vb_q == NONE) state_d = S_DONE;
        else if (va_q != NONE)            state_d = S_BR_RD;
        else                              state_d = S_MB;
      end
      S_MA_RD:   state_d = S_MA_CK;
      S_MA_CK:   state_d = (rd.vs == stamp_q) ? S_MM_PR : S_MB;
      S_MB:      state_d = (vb_q != NONE) ? S_BR_RD : S_MG;
      S_MB_RD:   state_d = S_MB_CK;
      S_MB_CK:   state_d = (rd.vs == stamp_q) ? S_MM_PR : S_MG;
      S_MM_PR: begin
        if (mi_q == mcnt) state_d = mside_q ? S_DONE : S_MM_PR;
        else              state_d = S_MM_RD;
      end
      S_MM_RD:   state_d = S_MM_WR;
      S_MM_WR: begin
        if ({1'b0, pidx_q} == lca_q && mside_q) state_d = S_DONE;
        else                                    state_d = S_MM_PR;
      end
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    sw_d = sw_q;  stamp_d = stamp_q;  bridge_d = bridge_q;
    vcount_d = cfg_we_i ? cfg_wdata_i : vcount_q;
    done_d = 1'b0;  res_d = res_q;
    bo_ret_d = bo_ret_q;  bo_v_d = bo_v_q;  bo_root_d = bo_root_q;  bo_x_d = bo_x_q;
    va_d = va_q;  vb_d = vb_q;  ca_d = ca_q;  cb_d = cb_q;
    cr_d = cr_q;  cx_d = cx_q;  csel_d = csel_q;
    top_d = top_q;  cur_d = cur_q;  below_d = below_q;  lca_d = lca_q;
    sz_d = sz_q;  na_d = na_q;  nb_d = nb_q;  mi_d = mi_q;  mside_d = mside_q;
    pidx_d = pidx_q;
    smem_req_o = '0;
    smem_req_o.wdata = rd;
    pmem_req_o = '0;
    case (state_q)
      S_INIT: begin
        smem_req_o.we       = 1'b1;
        smem_req_o.waddr    = VW'(sw_q);
        smem_req_o.wdata.bl = VW'(sw_q);
        smem_req_o.wdata.cl = VW'(sw_q);
        smem_req_o.wdata.tp = NONE;
        smem_req_o.wdata.ts = VX'(1);
        smem_req_o.wdata.vs = '0;
        sw_d = sw_q + AW'(1);
      end
      S_IDLE: begin
        if (start_i) begin
          if (err_w) begin
            done_d = 1'b1;
            res_d.bridge_count = bridge_q;
            res_d.index_error  = 1'b1;
          end else begin
            va_d = {1'b0, in_word_i.vertex_a};
            vb_d = {1'b0, in_word_i.vertex_b};
            bo_v_d = {1'b0, in_word_i.vertex_a};
            bo_root_d = {1'b0, in_word_i.vertex_a};
            bo_ret_d = S_A1;
          end
        end
      end
      // find block root, then compress the path onto it
      S_BR_RD: begin
        smem_req_o.re = 1'b1;
        smem_req_o.raddr = bo_root_q[VW-1:0];
      end
      S_BR_CK: begin
        if (rd_bl == bo_root_q) bo_x_d = bo_v_q;
        else                    bo_root_d = rd_bl;
      end
      S_BC_CK: begin
        if (bo_x_q != bo_root_q) begin
          smem_req_o.re = 1'b1;
          smem_req_o.raddr = bo_x_q[VW-1:0];
        end
      end
      S_BC_WR: begin
        smem_req_o.we = 1'b1;
        smem_req_o.waddr = bo_x_q[VW-1:0];
        smem_req_o.wdata.bl = bo_root_q[VW-1:0];
        bo_x_d = rd_bl;
      end
      S_A1: begin
        va_d = bo_root_q;
        bo_v_d = vb_q;  bo_root_d = vb_q;  bo_ret_d = S_B1;
      end
      S_B1: begin
        vb_d = bo_root_q;
        cr_d = va_q;  csel_d = 1'b0;
      end
      // component root walk and compression
      S_CR_RD: begin
        smem_req_o.re = 1'b1;
        smem_req_o.raddr = cr_q[VW-1:0];
      end
      S_CR_CK: begin
        if (rd_cl == cr_q) begin
          cx_d = csel_q ? vb_q : va_q;
        end else begin
          bo_v_d = rd_cl;  bo_root_d = rd_cl;  bo_ret_d = S_CR_RET;
        end
      end
      S_CR_RET: cr_d = bo_root_q;
      S_CX_CK: begin
        if (cx_q == cr_q) begin
          if (!csel_q) begin
            ca_d = cr_q;  csel_d = 1'b1;  cr_d = vb_q;
          end else begin
            cb_d = cr_q;
          end
        end else begin
          smem_req_o.re = 1'b1;
          smem_req_o.raddr = cx_q[VW-1:0];
        end
      end
      S_CX_BO: begin
        bo_v_d = rd_cl;  bo_root_d = rd_cl;  bo_ret_d = S_CX_RD;
      end
      S_CX_RD: begin
        smem_req_o.re = 1'b1;
        smem_req_o.raddr = cx_q[VW-1:0];
      end
      S_CX_WR: begin
        smem_req_o.we = 1'b1;
        smem_req_o.waddr = cx_q[VW-1:0];
        smem_req_o.wdata.cl = cr_q[VW-1:0];
        cx_d = bo_root_q;
      end
      S_CMP: begin
        if (ca_q != cb_q) begin
          bridge_d = bridge_q + VW'(1);
          smem_req_o.re = 1'b1;
          smem_req_o.raddr = ca_q[VW-1:0];
        end else begin
          stamp_d = (&stamp_q) ? SW'(1) : stamp_q + SW'(1);
          sw_d = '0;
          na_d = '0;  nb_d = '0;
        end
      end
      S_CMP_A: begin
        sz_d = rd.ts;
        smem_req_o.re = 1'b1;
        smem_req_o.raddr = cb_q[VW-1:0];
      end
      S_CMP_B: begin
        if (swap_w) begin
          va_d = vb_q;  vb_d = va_q;  ca_d = cb_q;  cb_d = ca_q;
        end
        top_d = swap_w ? vb_q : va_q;
        cur_d = swap_w ? vb_q : va_q;
        below_d = NONE;
      end
      // re-root the smaller tree at the edge's block
      S_RR_CK: begin
        if (cur_q != NONE) begin
          smem_req_o.re = 1'b1;
          smem_req_o.raddr = cur_q[VW-1:0];
        end
      end
      S_RR_BO: begin
        bo_v_d = rd.tp;  bo_root_d = rd.tp;  bo_ret_d = S_RR_RD;
      end
      S_RR_RD: begin
        smem_req_o.re = 1'b1;
        smem_req_o.raddr = cur_q[VW-1:0];
      end
      S_RR_WR: begin
        smem_req_o.we = 1'b1;
        smem_req_o.waddr = cur_q[VW-1:0];
        smem_req_o.wdata.tp = below_q;
        smem_req_o.wdata.cl = top_q[VW-1:0];
        below_d = cur_q;
        cur_d = bo_root_q;
      end
      S_RR_END: begin
        smem_req_o.re = 1'b1;
        smem_req_o.raddr = below_q[VW-1:0];
      end
      S_RR_SZ: begin
        sz_d = rd.ts;
        smem_req_o.re = 1'b1;
        smem_req_o.raddr = top_q[VW-1:0];
      end
      S_LK_WR: begin
        smem_req_o.we = 1'b1;
        smem_req_o.waddr = top_q[VW-1:0];
        smem_req_o.wdata.ts = sz_q;
        smem_req_o.wdata.tp = vb_q;
        smem_req_o.wdata.cl = vb_q[VW-1:0];
      end
      S_SZ_RD: begin
        smem_req_o.re = 1'b1;
        smem_req_o.raddr = cb_q[VW-1:0];
      end
      S_SZ_WR: begin
        smem_req_o.we = 1'b1;
        smem_req_o.waddr = cb_q[VW-1:0];
        smem_req_o.wdata.ts = rd.ts + sz_q;
      end
      // stamp wrap: clear every visit stamp
      S_WIPE_RD: begin
        smem_req_o.re = 1'b1;
        smem_req_o.raddr = VW'(sw_q);
      end
      S_WIPE_WR: begin
        smem_req_o.we = 1'b1;
        smem_req_o.waddr = VW'(sw_q);
        smem_req_o.wdata.vs = '0;
        sw_d = sw_q + AW'(1);
      end
      // climb both block paths until one meets a stamped block
      S_MG: begin
        if (va_q != NONE) begin
          bo_v_d = va_q;  bo_root_d = va_q;  bo_ret_d = S_MA_RD;
        end
      end
      S_MA_RD: begin
        va_d = bo_root_q;
        pmem_req_o.we = 1'b1;
        pmem_req_o.waddr = {1'b0, VW'(na_q[AW-1:0])};
        pmem_req_o.wdata = bo_root_q[VW-1:0];
        na_d = na_q + (AW+1)'(1);
        smem_req_o.re = 1'b1;
        smem_req_o.raddr = bo_root_q[VW-1:0];
      end
      S_MA_CK: begin
        if (rd.vs == stamp_q) begin
          lca_d = va_q;  mi_d = '0;  mside_d = 1'b0;
        end else begin
          smem_req_o.we = 1'b1;
          smem_req_o.waddr = va_q[VW-1:0];
          smem_req_o.wdata.vs = stamp_q;
          va_d = rd.tp;
        end
      end
      S_MB: begin
        if (vb_q != NONE) begin
          bo_v_d = vb_q;  bo_root_d = vb_q;  bo_ret_d = S_MB_RD;
        end
      end
      S_MB_RD: begin
        vb_d = bo_root_q;
        pmem_req_o.we = 1'b1;
        pmem_req_o.waddr = {1'b1, VW'(nb_q[AW-1:0])};
        pmem_req_o.wdata = bo_root_q[VW-1:0];
        nb_d = nb_q + (AW+1)'(1);
        smem_req_o.re = 1'b1;
        smem_req_o.raddr = bo_root_q[VW-1:0];
      end
      S_MB_CK: begin
        if (rd.vs == stamp_q) begin
          lca_d = vb_q;  mi_d = '0;  mside_d = 1'b0;
        end else begin
          smem_req_o.we = 1'b1;
          smem_req_o.waddr = vb_q[VW-1:0];
          smem_req_o.wdata.vs = stamp_q;
          vb_d = rd.tp;
        end
      end
      // fold both paths into the common block
      S_MM_PR: begin
        if (mi_q == mcnt) begin
          if (!mside_q) begin
            mside_d = 1'b1;  mi_d = '0;
          end
        end else begin
          pmem_req_o.re = 1'b1;
          pmem_req_o.raddr = {mside_q, VW'(mi_q[AW-1:0])};
        end
      end
      S_MM_RD: begin
        pidx_d = pmem_rdata_i;
        smem_req_o.re = 1'b1;
        smem_req_o.raddr = pmem_rdata_i;
      end
      S_MM_WR: begin
        smem_req_o.we = 1'b1;
        smem_req_o.waddr = pidx_q;
        smem_req_o.wdata.bl = lca_q[VW-1:0];
        if ({1'b0, pidx_q} == lca_q) begin
          mside_d = 1'b1;  mi_d = '0;
        end else begin
          bridge_d = bridge_q - VW'(1);
          mi_d = mi_q + (AW+1)'(1);
        end
      end
      S_DONE: begin
        done_d = 1'b1;
        res_d.bridge_count = bridge_q;
        res_d.index_error  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      sw_q     <= '0;
      stamp_q  <= '0;
      bridge_q <= '0;
      vcount_q <= CW'(1024);
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      sw_q     <= sw_d;
      stamp_q  <= stamp_d;
      bridge_q <= bridge_d;
      vcount_q <= vcount_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;  bo_ret_q <= bo_ret_d;
    bo_v_q <= bo_v_d;  bo_root_q <= bo_root_d;  bo_x_q <= bo_x_d;
    va_q <= va_d;  vb_q <= vb_d;  ca_q <= ca_d;  cb_q <= cb_d;
    cr_q <= cr_d;  cx_q <= cx_d;  csel_q <= csel_d;
    top_q <= top_d;  cur_q <= cur_d;  below_q <= below_d;  lca_q <= lca_d;
    sz_q <= sz_d;  na_q <= na_d;  nb_q <= nb_d;  mi_q <= mi_d;  mside_q <= mside_d;
    pidx_q <= pidx_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  `OBC_ASSERT(a_no_rw_clash, !(smem_req_o.re && smem_req_o.we), "state mem read and write together")
  `OBC_ASSERT_IMP(a_done_idle, done_q, state_q == S_IDLE, "result outside idle")
  `OBC_ASSERT_IMP(a_init_busy, state_q == S_INIT, busy_o, "not busy during init sweep")
  `OBC_ASSERT_IMP(a_merge_bound, state_q == S_MM_PR, mi_q <= mcnt, "merge index past path end")

endmodule
`default_nettype wire

FILE: tb/online_bridge_counter_top_test.sv
// Self-checking bench for online_bridge_counter_top: edges go in, bridge counts come out.
// Uses obc_pkg; a behavioral bridge forest inside predicts every result word.
`timescale 1ns / 1ps
module online_bridge_counter_top_test;
  import obc_pkg::*;

  localparam int unsigned NV = 1024;
  localparam int unsigned NOPAR = 32'hFFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam logic [CW-1:0] VCOUNT_RESET = 11'd1024;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_word_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CW-1:0] cfg_wdata_i = '0;
  logic done_o;
  out_word_t result_o;

  online_bridge_counter_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_word_i(in_word_i), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .done_o(done_o), .result_o(result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Bridge forest predictor: block union-find, component union-find, block tree
  // with sizes, visit stamps for the common-ancestor search.
  // ---------------------------------------------------------------------------
  int unsigned blk_link [NV];
  int unsigned comp_link[NV];
  int unsigned up_link  [NV];
  int unsigned comp_size[NV];
  int unsigned seen_mark[NV];
  int unsigned walk_a   [NV];
  int unsigned walk_b   [NV];
  int unsigned mark_ctr;
  int unsigned bridges;
  int unsigned vcount;

  out_word_t expected_words[$];
  int errors = 0;
  longint cycles = 0;

  function automatic int unsigned find_block(int unsigned v);
    int unsigned root, x, nx, n;
    if (v >= NV) return NOPAR;
    root = v; n = 0;
    while (blk_link[root] != root && n < NV) begin
      nx = blk_link[root];
      if (nx >= NV) break;
      root = nx; n++;
    end
    x = v; n = 0;
    while (x != root && n < NV) begin
      nx = blk_link[x];
      blk_link[x] = root;
      if (nx >= NV) break;
      x = nx; n++;
    end
    return root;
  endfunction

  function automatic int unsigned find_comp(int unsigned v);
    int unsigned root, x, nx, n;
    root = find_block(v);
    if (root == NOPAR) return NOPAR;
    n = 0;
    while (comp_link[root] != root && n < NV) begin
      nx = find_block(comp_link[root]);
      if (nx == NOPAR) break;
      root = nx; n++;
    end
    x = find_block(v); n = 0;
    while (x != root && n < NV) begin
      nx = find_block(comp_link[x]);
      comp_link[x] = root;
      if (nx == NOPAR) break;
      x = nx; n++;
    end
    return root;
  endfunction

  function automatic void reroot_tree(int unsigned v);
    int unsigned top, cur, below, upv, n;
    top = find_block(v);
    if (top == NOPAR) return;
    cur = top; below = NOPAR; n = 0;
    while (cur != NOPAR && n < NV) begin
      upv = find_block(up_link[cur]);
      up_link[cur] = below;
      comp_link[cur] = top;
      below = cur; cur = upv; n++;
    end
    comp_size[top] = comp_size[below];
  endfunction

  function automatic void fold_cycle(int unsigned a, int unsigned b);
    int unsigned na, nb, lca, n;
    na = 0; nb = 0; lca = NOPAR; n = 0;
    mark_ctr++;
    if (mark_ctr == 0) begin
      foreach (seen_mark[i]) seen_mark[i] = 0;
      mark_ctr = 1;
    end
    while (lca == NOPAR && n < 2 * NV + 2) begin
      n++;
      if (a == NOPAR && b == NOPAR) break;
      if (a != NOPAR) begin
        a = find_block(a);
        if (a == NOPAR || na >= NV) break;
        walk_a[na] = a;
        na++;
        if (seen_mark[a] == mark_ctr) begin
          lca = a;
          break;
        end
        seen_mark[a] = mark_ctr;
        a = up_link[a];
      end
      if (b != NOPAR) begin
        b = find_block(b);
        if (b == NOPAR || nb >= NV) break;
        walk_b[nb] = b;
        nb++;
        if (seen_mark[b] == mark_ctr) begin
          lca = b;
          break;
        end
        seen_mark[b] = mark_ctr;
        b = up_link[b];
      end
    end
    if (lca == NOPAR) return;
    for (int unsigned i = 0; i < na; i++) begin
      blk_link[walk_a[i]] = lca;
      if (walk_a[i] == lca) break;
      bridges = (bridges - 1) & 10'h3FF;
    end
    for (int unsigned i = 0; i < nb; i++) begin
      blk_link[walk_b[i]] = lca;
      if (walk_b[i] == lca) break;
      bridges = (bridges - 1) & 10'h3FF;
    end
  endfunction

  function automatic void insert_link(int unsigned a, int unsigned b);
    int unsigned ca, cb, t;
    a = find_block(a);
    b = find_block(b);
    if (a == b || a == NOPAR || b == NOPAR) return;
    ca = find_comp(a);
    cb = find_comp(b);
    if (ca == NOPAR || cb == NOPAR) return;
    if (ca != cb) begin
      bridges = (bridges + 1) & 10'h3FF;
      if (comp_size[ca] > comp_size[cb]) begin
        t = a; a = b; b = t;
        t = ca; ca = cb; cb = t;
      end
      reroot_tree(a);
      up_link[a] = b;
      comp_link[a] = b;
      comp_size[cb] += comp_size[a];
    end else begin
      fold_cycle(a, b);
    end
  endfunction

  function automatic out_word_t predict_bridges(in_word_t w);
    out_word_t r;
    r.index_error = (w.vertex_a >= vcount) || (w.vertex_b >= vcount);
    if (!r.index_error) insert_link(w.vertex_a, w.vertex_b);
    r.bridge_count = bridges[VW-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result check: every done_o word against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    $display("[%0t] %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with nothing pending");
      end else begin
        out_word_t e;
        e = expected_words.pop_front();
        if (result_o.bridge_count !== e.bridge_count)
          report_mismatch($sformatf("bridge_count got %0d want %0d",
                                    result_o.bridge_count, e.bridge_count));
        if (result_o.index_error !== e.index_error)
          report_mismatch($sformatf("index_error got %0b want %0b",
                                    result_o.index_error, e.index_error));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("online_bridge_counter_top: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // one edge word: random gap, hold start until the block takes it; start stays
  // high after the taking edge, so a zero gap offers the next word at once
  task automatic send_edge(int unsigned a, int unsigned b);
    int unsigned gap;
    in_word_t w;
    out_word_t pw;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    w.vertex_a = a[VW-1:0];
    w.vertex_b = b[VW-1:0];
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (busy);
    pw = predict_bridges(w);
    expected_words.insert(expected_words.size(), pw);
  endtask

  // pause the sender until every pending word is back
  task automatic drain();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // vertex_count is only written with the block idle
  task automatic set_vertex_count(int unsigned n);
    drain();
    while (busy) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= n[CW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    vcount = n & 11'h7FF;
    @(posedge clk_i);
  endtask

  function automatic int unsigned pick(int unsigned lo, int unsigned hi);
    return $urandom_range(lo, hi);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // self-loop, first bridge, cycle collapse, same-block edge, range errors
  task automatic test_directed();
    send_edge(0, 0);
    send_edge(0, 1);
    send_edge(1, 2);
    send_edge(2, 3);
    send_edge(3, 1);        // closes a cycle: two bridges go away
    send_edge(2, 1);        // ends already in one block
    send_edge(1023, 1022);
    send_edge(1022, 0);
    send_edge(1023, 3);     // cycle across the whole component
    send_edge(682, 341);
    send_edge(341, 682);
    drain();
    set_vertex_count(1);
    send_edge(0, 0);
    send_edge(0, 1);        // b out of range
    send_edge(1, 0);        // a out of range
    send_edge(1023, 1023);
    set_vertex_count(2047); // wider than the vertex field: all in range
    send_edge(1023, 1);
    send_edge(512, 511);
    set_vertex_count(VCOUNT_RESET);
    send_edge(1023, 512);
  endtask

  // long run of random edges across the full vertex range
  task automatic test_tree_growth(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      int unsigned v;
      v = pick(4, 1023);
      send_edge(v, pick(0, 1023));
    end
  endtask

  // small vertex sets: quick cycles and many same-block edges
  task automatic test_dense(int unsigned nv, int unsigned n);
    set_vertex_count(nv);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_edge(pick(0, 1023), pick(0, 1023));   // mostly out of range
      else
        send_edge(pick(0, nv - 1), pick(0, nv - 1));
      if (i % 97 == 96) drain();
    end
  endtask

  // partial range with full-width vertex numbers: mixed errors and edges
  task automatic test_mixed_range(int unsigned n);
    set_vertex_count(1000);
    for (int unsigned i = 0; i < n; i++)
      send_edge(pick(0, 1023), pick(0, 1023));
  endtask

  initial begin
    foreach (blk_link[i]) begin
      blk_link[i] = i;
      comp_link[i] = i;
      up_link[i] = NOPAR;
      comp_size[i] = 1;
      seen_mark[i] = 0;
    end
    mark_ctr = 0;
    bridges = 0;
    vcount = VCOUNT_RESET;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);   // post-reset memory sweep

    test_directed();
    test_tree_growth(650);
    drain();
    test_dense(16, 300);
    test_dense(64, 250);
    test_mixed_range(200);
    set_vertex_count(VCOUNT_RESET);
    test_tree_growth(130);

    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("online_bridge_counter_top: match");
    end else begin
      $display("online_bridge_counter_top: mismatch");
    end
    $finish;
  end

endmodule
